/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante holds
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/cdsr_pkg.sv */
// ---------------------------------------------------------------------------
// cdsr_pkg
// Types and constants for the central difference slope ratio block.
// ---------------------------------------------------------------------------
package cdsr_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int RATIO_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PAIR_W      = 3;
    localparam int VARS_W      = 3;
    localparam int MIN_DEN_W   = 33;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 33;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VARS_IN_USE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DENOMINATOR = 2'd1;

    localparam logic [VARS_W-1:0]    VARS_RESET   = 3'd4;
    localparam logic [RATIO_W-1:0]   RATIO_MAX    = 32'h7FFF_FFFF;
    localparam logic [RATIO_W-1:0]   RATIO_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic                       trial_start;
    } sample_payload_t;

    typedef struct packed {
        logic [PAIR_W-1:0]         pair_row;
        logic signed [RATIO_W-1:0] ratio;
        logic                      ratio_valid;
        logic                      saturated;
        logic                      last_of_run;
    } ratio_payload_t;

    // Quotient handed from the divider to the sequencer
    typedef struct packed {
        logic signed [RATIO_W-1:0] ratio;
        logic                      sat;
    } div_result_t;

endpackage

/* hdl/cdsr_stream_if.sv */
// ---------------------------------------------------------------------------
// cdsr_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface cdsr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/cdsr_divider.sv */
// ---------------------------------------------------------------------------
// cdsr_divider
// Bit-serial restoring divider: Q16.16 quotient of two signed differences,
// one quotient bit per cycle, clamped to the signed 32-bit range.
// ---------------------------------------------------------------------------
module cdsr_divider
    import cdsr_pkg::*;
#(
    parameter int DIFF_W = 33
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] num,
    input  logic signed [DIFF_W-1:0] den,
    output div_result_t              result,
    output logic                     done
);

    localparam int NUM_W = DIFF_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} div_state_t;

    div_state_t          state_reg;
    logic [NUM_W-1:0]    num_sh_reg;
    logic [DIFF_W-1:0]   den_reg;
    logic [DIFF_W-1:0]   rem_reg;
    logic [RATIO_W-1:0]  quo_reg;
    logic                ovf_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg;
    div_result_t         result_reg;
    logic                done_reg;

    logic [DIFF_W-1:0]   num_mag;
    logic [DIFF_W-1:0]   den_mag;
    logic [DIFF_W:0]     rem_sh;
    logic [DIFF_W:0]     trial;
    logic                bit_ge;
    logic [DIFF_W-1:0]   rem_next;
    logic [RATIO_W-1:0]  limit;
    logic                over;
    logic [RATIO_W-1:0]  mag;

    // Operand magnitudes
    assign num_mag = num[DIFF_W-1] ? DIFF_W'(0) - num : num;
    assign den_mag = den[DIFF_W-1] ? DIFF_W'(0) - den : den;

    // One restoring step: shift in the next numerator bit, try to subtract
    assign rem_sh   = {rem_reg, num_sh_reg[NUM_W-1]};
    assign trial    = rem_sh - {1'b0, den_reg};
    assign bit_ge   = ~trial[DIFF_W];
    assign rem_next = bit_ge ? trial[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];

    // Clamp the finished quotient
    assign limit = neg_reg ? RATIO_MIN : RATIO_MAX;
    assign over  = ovf_reg || (quo_reg > limit);
    assign mag   = over ? limit : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Pulse done for one cycle as the result register loads
            done_reg <= (state_reg == DV_FIN);
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        num_sh_reg <= {num_mag, {FRAC_BITS{1'b0}}};
                        den_reg    <= den_mag;
                        neg_reg    <= num[DIFF_W-1] ^ den[DIFF_W-1];
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                        ovf_reg    <= 1'b0;
                        cnt_reg    <= '0;
                        state_reg  <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    num_sh_reg <= {num_sh_reg[NUM_W-2:0], 1'b0};
                    rem_reg    <= rem_next;
                    quo_reg    <= {quo_reg[RATIO_W-2:0], bit_ge};
                    ovf_reg    <= ovf_reg | quo_reg[RATIO_W-1];
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN:
                begin
                    result_reg.ratio <= neg_reg ? RATIO_W'(0) - mag : mag;
                    result_reg.sat   <= over;
                    state_reg        <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* hdl/central_difference_slope_ratio_top.sv */
// A new sample is taken only once the last pair of the previous point has been loaded
//   into the output register; the bit-serial divider, one bit a cycle, sets the pace.
// Samples that complete no point leave the block idle and ready for the next sample.
// Reset (rst_n, asynchronous, active low) clears the stored points and the
//   registers to vars_in_use = 4 and min_denominator = 0.
// ---------------------------------------------------------------------------
// central_difference_slope_ratio_top
// Keeps the last two samples of a trial and emits, for each new point, the
// ratio of central differences of every variable pair through a shared divider.
// ---------------------------------------------------------------------------
module central_difference_slope_ratio_top
    import cdsr_pkg::*;
#(
    parameter int MAX_VARS    = 4,
    parameter int SAMPLE_BITS = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    cdsr_stream_if.sink            samples,
    cdsr_stream_if.source          ratios
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int IDX_W  = $clog2(MAX_VARS);
    localparam int CMP_W  = (DIFF_W > MIN_DEN_W) ? DIFF_W : MIN_DEN_W;

    typedef enum logic [2:0] {ST_IDLE, ST_ROW, ST_PAIR, ST_DIV, ST_EMIT} seq_state_t;

    // Configuration
    logic [VARS_W-1:0]    vars_in_use_reg;
    logic [MIN_DEN_W-1:0] min_den_reg;

    // Trial history
    logic [SAMPLE_BITS-1:0] older_reg [MAX_VARS];
    logic [SAMPLE_BITS-1:0] newer_reg [MAX_VARS];
    logic [1:0]             points_seen_reg;

    // Pair sequencer
    seq_state_t                 state_reg;
    logic signed [DIFF_W-1:0]   row_reg  [MAX_VARS];
    logic signed [DIFF_W-1:0]   scan_reg [MAX_VARS];
    logic signed [DIFF_W-1:0]   num_reg;
    logic [IDX_W-1:0]           i_reg;
    logic [IDX_W-1:0]           j_reg;
    logic [IDX_W-1:0]           nm1_reg;
    logic [PAIR_W-1:0]          count_reg;
    logic                       res_valid_reg;

    // Output register
    logic           out_valid_reg;
    logic           out_valid_next;
    ratio_payload_t out_payload_reg;

    logic [SAMPLE_W-1:0]      raw      [4];
    logic [SAMPLE_BITS-1:0]   cur      [MAX_VARS];
    logic signed [DIFF_W-1:0] diff_in  [MAX_VARS];
    logic [1:0]               ps_eff;
    logic [IDX_W-1:0]         nm1_clamped;
    logic [DIFF_W-1:0]        den_mag;
    logic                     den_ok;
    logic                     div_start;
    div_result_t              div_res;
    logic                     div_done;
    logic                     out_free;
    logic                     row_end;
    logic                     run_end;

    // Take each field as SAMPLE_BITS-bit two's complement
    assign raw[0] = samples.payload.sample_0;
    assign raw[1] = samples.payload.sample_1;
    assign raw[2] = samples.payload.sample_2;
    assign raw[3] = samples.payload.sample_3;

    generate
        for (genvar v = 0; v < MAX_VARS; v++)
        begin : g_var
            if (SAMPLE_BITS <= SAMPLE_W)
            begin : g_trunc
                assign cur[v] = raw[v][SAMPLE_BITS-1:0];
            end
            else
            begin : g_ext
                assign cur[v] = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, raw[v]};
            end
            assign diff_in[v] = {cur[v][SAMPLE_BITS-1], cur[v]}
                              - {older_reg[v][SAMPLE_BITS-1], older_reg[v]};
        end
    endgenerate

    // Effective point count and clamped last variable index
    assign ps_eff = samples.payload.trial_start ? 2'd0 : points_seen_reg;

    always_comb
    begin
        if (vars_in_use_reg < VARS_W'(2))
        begin
            nm1_clamped = IDX_W'(1);
        end
        else if (vars_in_use_reg > VARS_W'(MAX_VARS))
        begin
            nm1_clamped = IDX_W'(MAX_VARS - 1);
        end
        else
        begin
            nm1_clamped = IDX_W'(vars_in_use_reg - VARS_W'(1));
        end
    end

    // Denominator threshold test
    assign den_mag = scan_reg[0][DIFF_W-1] ? DIFF_W'(0) - scan_reg[0] : scan_reg[0];
    assign den_ok  = CMP_W'(den_mag) > CMP_W'(min_den_reg);

    assign div_start = (state_reg == ST_PAIR) && den_ok;
    assign out_free  = !out_valid_reg || ratios.ready;
    assign row_end   = (j_reg == nm1_reg);
    assign run_end   = row_end && (i_reg == nm1_reg - IDX_W'(1));

    // Output valid: load on an emit, drop once the transaction is taken
    assign out_valid_next = ((state_reg == ST_EMIT) && out_free)
                         || (out_valid_reg && !ratios.ready);

    cdsr_divider #(
        .DIFF_W (DIFF_W)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_reg),
        .den    (scan_reg[0]),
        .result (div_res),
        .done   (div_done)
    );

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vars_in_use_reg <= VARS_RESET;
            min_den_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VARS_IN_USE:     vars_in_use_reg <= cfg_data[VARS_W-1:0];
                REG_MIN_DENOMINATOR: min_den_reg     <= cfg_data[MIN_DEN_W-1:0];
                default:             ;
            endcase
        end
    end

    // Sequencer: capture a point, walk the pairs, load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            points_seen_reg <= 2'd0;
            out_valid_reg   <= 1'b0;
            for (int v = 0; v < MAX_VARS; v++)
            begin
                older_reg[v] <= '0;
                newer_reg[v] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (samples.valid)
                    begin
                        for (int v = 0; v < MAX_VARS; v++)
                        begin
                            older_reg[v] <= newer_reg[v];
                            newer_reg[v] <= cur[v];
                            row_reg[v]   <= diff_in[v];
                        end
                        points_seen_reg <= (ps_eff < 2'd2) ? ps_eff + 2'd1 : ps_eff;
                        if (ps_eff == 2'd2)
                        begin
                            nm1_reg   <= nm1_clamped;
                            i_reg     <= '0;
                            count_reg <= '0;
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_ROW:
                begin
                    // Numerator for this row; scan line starts at the next variable
                    num_reg <= row_reg[0];
                    for (int k = 0; k < MAX_VARS - 1; k++)
                    begin
                        row_reg[k]  <= row_reg[k+1];
                        scan_reg[k] <= row_reg[k+1];
                    end
                    row_reg[MAX_VARS-1]  <= '0;
                    scan_reg[MAX_VARS-1] <= '0;
                    j_reg     <= i_reg + IDX_W'(1);
                    state_reg <= ST_PAIR;
                end
                ST_PAIR:
                begin
                    res_valid_reg <= den_ok;
                    state_reg     <= den_ok ? ST_DIV : ST_EMIT;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_payload_reg.pair_row    <= count_reg;
                        out_payload_reg.ratio       <= res_valid_reg ? div_res.ratio : '0;
                        out_payload_reg.ratio_valid <= res_valid_reg;
                        out_payload_reg.saturated   <= res_valid_reg && div_res.sat;
                        out_payload_reg.last_of_run <= run_end;
                        count_reg <= count_reg + PAIR_W'(1);
                        for (int k = 0; k < MAX_VARS - 1; k++)
                        begin
                            scan_reg[k] <= scan_reg[k+1];
                        end
                        scan_reg[MAX_VARS-1] <= '0;
                        j_reg <= j_reg + IDX_W'(1);
                        if (run_end)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (row_end)
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_ROW;
                        end
                        else
                        begin
                            state_reg <= ST_PAIR;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign samples.ready  = (state_reg == ST_IDLE);
    assign ratios.valid   = out_valid_reg;
    assign ratios.payload = out_payload_reg;

endmodule

/* hdl/cdsr_checker.sv */
// ---------------------------------------------------------------------------
// cdsr_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdsr_checker
    import cdsr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [PAIR_W-1:0]   pair_row,
    input logic [RATIO_W-1:0]  ratio,
    input logic                ratio_valid,
    input logic                saturated,
    input logic                last_of_run
);

    // Keep valid high while a result is stalled
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A refused denominator carries no quotient
    `ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_valid && !ratio_valid, ratio == '0 && !saturated)

    // A clamped quotient sits at one of the range ends
    `ASSERT_IMPLY(a_sat_clamp, clk, rst_n, out_valid && saturated, ratio == RATIO_MAX || ratio == RATIO_MIN)

    // The sixth pair always closes its point
    `ASSERT_IMPLY(a_last_pair, clk, rst_n, out_valid && pair_row == 3'd5, last_of_run)

endmodule

bind central_difference_slope_ratio_top cdsr_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (ratios.valid),
    .out_ready   (ratios.ready),
    .pair_row    (ratios.payload.pair_row),
    .ratio       (ratios.payload.ratio),
    .ratio_valid (ratios.payload.ratio_valid),
    .saturated   (ratios.payload.saturated),
    .last_of_run (ratios.payload.last_of_run)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for central_difference_slope_ratio_top. It computes
// the expected pair ratios of each accepted sample and checks every result
// transaction against them, in order, under random idling on both channels,
// through several settings of both registers.
// ---------------------------------------------------------------------------
module tb;
    import cdsr_pkg::*;

    localparam int NUM_VARS        = 4;
    localparam int DRAIN_CYCLES    = 120;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 2500;

    // Indexes that map to no register
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic [CFG_DATA_W-1:0]      DEN_FULL = 33'h1_FFFF_FFFF;

    // -----------------------------------------------------------------------
    // Slope ratio scoreboard: predicts the pair ratios and checks results
    // -----------------------------------------------------------------------
    class slope_ratio_scoreboard;
        logic [VARS_W-1:0]          vars_cfg = VARS_RESET;
        logic [MIN_DEN_W-1:0]       min_den = '0;
        logic signed [SAMPLE_W-1:0] older_pt[NUM_VARS] = '{default: '0};
        logic signed [SAMPLE_W-1:0] newer_pt[NUM_VARS] = '{default: '0};
        int                         points_held = 0;
        ratio_payload_t             pending[$];
        int                         errors = 0;

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        endtask

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VARS_IN_USE:     vars_cfg = data[VARS_W-1:0];
                REG_MIN_DENOMINATOR: min_den = data[MIN_DEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Q16.16 quotient di/dj, truncated toward zero and clamped
        function ratio_payload_t pair_ratio(longint di, longint dj, int row, bit last);
            ratio_payload_t     r;
            longint unsigned    num_mag;
            longint unsigned    den_mag;
            longint unsigned    quot;
            longint unsigned    limit;
            logic [63:0]        signed_quot;
            bit                 neg;
            r = '0;
            r.pair_row = row[PAIR_W-1:0];
            r.last_of_run = last;
            den_mag = (dj < 0) ? longint'(-dj) : longint'(dj);
            if (den_mag > 64'(min_den))
            begin
                r.ratio_valid = 1'b1;
                num_mag = (di < 0) ? longint'(-di) : longint'(di);
                neg = (di < 0) != (dj < 0);
                limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                quot = (num_mag << FRAC_BITS) / den_mag;
                if (quot > limit)
                begin
                    quot = limit;
                    r.saturated = 1'b1;
                end
                signed_quot = neg ? (64'd0 - quot) : quot;
                r.ratio = signed_quot[RATIO_W-1:0];
            end
            return r;
        endfunction

        // Note an accepted sample: queue its results and advance the window
        function void note_sample(sample_payload_t s);
            logic signed [SAMPLE_W-1:0] cur[NUM_VARS];
            ratio_payload_t exp_item;
            int n;
            int row;
            int total;
            longint di;
            longint dj;
            cur[0] = s.sample_0;
            cur[1] = s.sample_1;
            cur[2] = s.sample_2;
            cur[3] = s.sample_3;
            n = int'(vars_cfg);
            if (n < 2)
                n = 2;
            if (n > NUM_VARS)
                n = NUM_VARS;
            if (s.trial_start)
                points_held = 0;
            if (points_held >= 2)
            begin
                total = n * (n - 1) / 2;
                row = 0;
                for (int i = 0; i < n; i++)
                begin
                    for (int j = i + 1; j < n; j++)
                    begin
                        di = longint'(cur[i]) - longint'(older_pt[i]);
                        dj = longint'(cur[j]) - longint'(older_pt[j]);
                        exp_item = pair_ratio(di, dj, row, row == total - 1);
                        pending.insert(pending.size(), exp_item);
                        row++;
                    end
                end
            end
            for (int v = 0; v < NUM_VARS; v++)
            begin
                older_pt[v] = newer_pt[v];
                newer_pt[v] = cur[v];
            end
            if (points_held < 2)
                points_held++;
        endfunction

        // Check one result transaction against the oldest expectation
        task check_ratio(ratio_payload_t got);
            ratio_payload_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result, pair_row", got.pair_row, 0);
                return;
            end
            want = pending.pop_front();
            if (got.pair_row !== want.pair_row)
                report("pair_row", got.pair_row, want.pair_row);
            if (got.ratio !== want.ratio)
                report("ratio", got.ratio, want.ratio);
            if (got.ratio_valid !== want.ratio_valid)
                report("ratio_valid", got.ratio_valid, want.ratio_valid);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", got.last_of_run, want.last_of_run);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cdsr_stream_if #(.payload_t(sample_payload_t)) sample_ch ();
    cdsr_stream_if #(.payload_t(ratio_payload_t))  ratio_ch ();

    slope_ratio_scoreboard sb;

    logic signed [SAMPLE_W-1:0] track[NUM_VARS];
    int trial_left;
    int hold_off;
    int stall_left;
    int cycles;
    bit no_idle;

    central_difference_slope_ratio_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .ratios    (ratio_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stall in random bursts, hold off on request, check each transaction
    initial
    begin
        ratio_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                ratio_ch.ready = 1'b0;
                hold_off--;
            end
            else if (no_idle)
                ratio_ch.ready = 1'b1;
            else if (stall_left > 0)
            begin
                ratio_ch.ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                ratio_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 15) - 1;
            end
            else
                ratio_ch.ready = 1'b1;
            @(posedge clk);
            if (ratio_ch.valid === 1'b1 && ratio_ch.ready === 1'b1)
                sb.check_ratio(ratio_ch.payload);
        end
    end

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Offer one sample, after an optional gap, and hold it until accepted
    task automatic send_sample(sample_payload_t p);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid   = 1'b1;
        sample_ch.payload = p;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        sb.note_sample(p);
        @(negedge clk);
    endtask

    task automatic send_vec(logic signed [SAMPLE_W-1:0] s0, logic signed [SAMPLE_W-1:0] s1,
                            logic signed [SAMPLE_W-1:0] s2, logic signed [SAMPLE_W-1:0] s3,
                            bit start);
        sample_payload_t p;
        p.sample_0    = s0;
        p.sample_1    = s1;
        p.sample_2    = s2;
        p.sample_3    = s3;
        p.trial_start = start;
        track = '{s0, s1, s2, s3};
        send_sample(p);
    endtask

    // Random trials: mostly smooth walks, some jumps, some held variables
    task automatic send_random(int count);
        logic signed [SAMPLE_W-1:0] stride;
        int kind;
        int k;
        bit start;
        for (int n = 0; n < count; n++)
        begin
            start = 1'b0;
            if (trial_left == 0)
            begin
                start = 1'b1;
                trial_left = $urandom_range(1, 14);
            end
            trial_left--;
            for (int v = 0; v < NUM_VARS; v++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                    track[v] = $urandom;
                else if (kind >= 4)
                begin
                    k = $urandom_range(0, 24);
                    stride = $urandom_range(0, 1 << k);
                    if ($urandom_range(0, 1) == 1)
                        stride = -stride;
                    track[v] = track[v] + stride;
                end
            end
            send_vec(track[0], track[1], track[2], track[3], start);
        end
    endtask

    // Drop valid, drain all expected results, then let the divider settle
    task automatic wait_idle();
        sample_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(logic [VARS_W-1:0] vars, logic [CFG_DATA_W-1:0] den, int count);
        logic [CFG_DATA_W-1:0] vars_word;
        wait_idle();
        vars_word = {$urandom, 1'b0};
        vars_word[VARS_W-1:0] = vars;
        write_reg(REG_VARS_IN_USE, vars_word);
        write_reg(REG_MIN_DENOMINATOR, den);
        send_random(count);
    endtask

    // Stimulus
    initial
    begin
        sb = new;
        cycles = 0;
        hold_off = 0;
        stall_left = 0;
        trial_left = 0;
        no_idle = 1'b0;
        track = '{default: '0};
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: exact -2^31, clamps both ways, zero denominators, extremes
        send_vec(0, 0, 0, 0, 1'b1);
        send_vec(0, 0, 0, 0, 1'b0);
        send_vec(-32768, 1, -32769, 32768, 1'b0);
        send_vec(32768, 1, -1, S_MAX, 1'b0);
        send_vec(-65537, 2, -32769, S_MIN, 1'b0);
        send_vec(S_MIN, S_MAX, S_MIN, S_MIN, 1'b0);
        send_vec(S_MAX, S_MIN, S_MAX, S_MAX, 1'b0);
        send_vec(0, -1, 0, 1, 1'b0);
        // New trial in the middle, then a trial cut short after two points
        send_vec(5, 5, 5, 5, 1'b1);
        send_vec(6, 6, 6, 6, 1'b0);
        send_vec(1, 2, 3, 4, 1'b1);
        send_vec(2, 3, 4, 5, 1'b0);
        send_vec(3, 5, 2, 7, 1'b0);
        send_vec(S_MAX, 0, S_MIN, -7, 1'b0);

        // Random phases across register settings; trials run on across phases
        run_phase(3'd2, '0, 20);
        run_phase(3'd3, 33'h1_0000, 25);
        // Hold off the result side so the block backs up into its input
        wait_idle();
        hold_off = HOLD_OFF_CYCLES;
        run_phase(3'd4, 33'd3, 25);
        run_phase(3'd0, 33'($urandom_range(0, 255)), 20);
        run_phase(3'd1, '0, 15);
        run_phase(3'd7, DEN_FULL, 15);
        wait_idle();
        write_reg(REG_SPARE_A, {$urandom, 1'b1});
        write_reg(REG_SPARE_B, {$urandom, 1'b0});
        run_phase(3'd5, {$urandom, 1'b1}, 20);
        run_phase(3'd4, 33'($urandom_range(0, 1 << 20)), 25);
        run_phase(3'd6, 33'd1, 20);
        // Last stretch runs with no idling on either side
        wait_idle();
        no_idle = 1'b1;
        run_phase(3'd4, '0, 25);
        wait_idle();

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cdsr_pkg.sv
hdl/cdsr_stream_if.sv
hdl/cdsr_divider.sv
hdl/central_difference_slope_ratio_top.sv
hdl/cdsr_checker.sv
tb/tb.sv
